// ===== rtl/core/mtbs_pkg.sv =====
// Package for the monotone table bracket search block.
// Holds field widths, command codes, controller states and the command/status structs.
// No dependencies.
package mtbs_pkg;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic REG_LAST_INDEX = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_DIR,
    ST_STEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic rd_first;
    logic rd_last;
    logic dir;
    logic step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic span_gt1;
    logic more;
  } dp_stat_t;

endpackage

// ===== rtl/core/mtbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mtbs_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mtbs_ctrl.sv =====
// Controller state machine for the bracket search: sequences table reads and bisection steps.
// Depends on mtbs_pkg.
module mtbs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  output logic              out_valid,
  input  logic              out_ready,
  input  mtbs_pkg::dp_stat_t stat,
  output mtbs_pkg::dp_cmd_t  cmd
);
  import mtbs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (command == CMD_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = ST_RD_FIRST;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      ST_RD_FIRST: begin
        cmd.rd_first = 1'b1;
        state_next   = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        cmd.rd_last = 1'b1;
        state_next  = ST_DIR;
      end
      ST_DIR: begin
        cmd.dir    = 1'b1;
        state_next = stat.span_gt1 ? ST_STEP : ST_DONE;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = stat.more ? ST_STEP : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/mtbs_dp.sv =====
// Datapath for the bracket search: value table, bisection bounds, direction and result registers.
// Depends on mtbs_pkg and mtbs_ram.
module mtbs_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk,
  input  mtbs_pkg::dp_cmd_t           cmd,
  output mtbs_pkg::dp_stat_t          stat,
  input  logic [mtbs_pkg::IDX_W-1:0]  last_index,
  input  logic [mtbs_pkg::IDX_W-1:0]  entry_index,
  input  logic [mtbs_pkg::DATA_W-1:0] entry_value,
  input  logic [mtbs_pkg::DATA_W-1:0] query,
  output logic [mtbs_pkg::IDX_W-1:0]  lower_index,
  output logic [mtbs_pkg::IDX_W-1:0]  upper_index
);
  import mtbs_pkg::*;

  localparam int          AW      = $clog2(TABLE_DEPTH);
  localparam logic [31:0] DEPTH_U = 32'(TABLE_DEPTH);

  logic [IDX_W-1:0]  n_sat;
  logic [IDX_W-1:0]  n_r;
  logic [IDX_W-1:0]  lo;
  logic [IDX_W-1:0]  hi;
  logic [IDX_W-1:0]  mid_r;
  logic [IDX_W-1:0]  lo_new;
  logic [IDX_W-1:0]  hi_new;
  logic [IDX_W:0]    sum_cur;
  logic [IDX_W:0]    sum_new;
  logic [IDX_W-1:0]  mid_cur;
  logic [IDX_W-1:0]  mid_new;
  logic [DATA_W-1:0] query_r;
  logic [DATA_W-1:0] first_r;
  logic [DATA_W-1:0] rdata;
  logic              rising;
  logic              at_or_above;
  logic              go_lo;
  logic              we;
  logic [AW-1:0]     raddr;

  assign n_sat = (32'(last_index) >= DEPTH_U) ? IDX_W'(TABLE_DEPTH - 1) : last_index;

  assign we = cmd.load_wr && (32'(entry_index) < DEPTH_U);

  mtbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(entry_index)),
    .wdata (entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign at_or_above = $signed(query_r) >= $signed(rdata);
  assign go_lo       = (at_or_above == rising);
  assign lo_new      = go_lo ? mid_r : lo;
  assign hi_new      = go_lo ? hi : mid_r;

  assign sum_cur = {1'b0, lo} + {1'b0, hi};
  assign mid_cur = sum_cur[IDX_W:1];
  assign sum_new = {1'b0, lo_new} + {1'b0, hi_new};
  assign mid_new = sum_new[IDX_W:1];

  assign stat = '{
    span_gt1: ({1'b0, hi} > ({1'b0, lo} + (IDX_W + 1)'(1))),
    more:     ({1'b0, hi_new} > ({1'b0, lo_new} + (IDX_W + 1)'(1)))
  };

  always_comb begin
    raddr = '0;
    if (cmd.rd_last) begin
      raddr = AW'(n_r);
    end else if (cmd.dir) begin
      raddr = AW'(mid_cur);
    end else if (cmd.step) begin
      raddr = AW'(mid_new);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo      <= '0;
      hi      <= n_sat;
      n_r     <= n_sat;
      query_r <= query;
    end
    if (cmd.rd_last) begin
      first_r <= rdata;
    end
    if (cmd.dir) begin
      rising <= $signed(rdata) >= $signed(first_r);
      mid_r  <= mid_cur;
    end
    if (cmd.step) begin
      lo    <= lo_new;
      hi    <= hi_new;
      mid_r <= mid_new;
    end
    if (cmd.out_load) begin
      lower_index <= lo;
      upper_index <= hi;
    end
  end

endmodule

// ===== rtl/core/monotone_table_bracket_search_top.sv =====
// Channel    | Signals                                          | Transaction
// input      | in_valid/in_ready, command, entry_index,         | one load or search
//            | entry_value, query                               |
// output     | out_valid/out_ready, lower_index, upper_index    | one bracket per search
// config     | psel, penable, pwrite, paddr, pwdata, prdata     | last_index register
//
// A search makes one table read per bisection step through the RAM's registered read.
// Input is taken only in idle.
// Reset clears control state only; table entries are undefined until loaded.
// A finished result waits in the output register; new input is taken while it waits, but a
// second search holds in its last state until that result is taken.
// Top level: config register, controller and datapath. Depends on mtbs_pkg, mtbs_ctrl, mtbs_dp.
module monotone_table_bracket_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mtbs_pkg::PADDR_W-1:0] paddr,
  input  logic [mtbs_pkg::PDATA_W-1:0] pwdata,
  output logic [mtbs_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         command,
  input  logic [mtbs_pkg::IDX_W-1:0]   entry_index,
  input  logic [mtbs_pkg::DATA_W-1:0]  entry_value,
  input  logic [mtbs_pkg::DATA_W-1:0]  query,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mtbs_pkg::IDX_W-1:0]   lower_index,
  output logic [mtbs_pkg::IDX_W-1:0]   upper_index
);
  import mtbs_pkg::*;

  logic [IDX_W-1:0] last_index;
  logic             reg_sel;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_LAST_INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_index <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      last_index <= pwdata[IDX_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(PDATA_W - IDX_W){1'b0}}, last_index} : '0;

  mtbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mtbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .stat        (stat),
    .last_index  (last_index),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .query       (query),
    .lower_index (lower_index),
    .upper_index (upper_index)
  );

endmodule

// ===== rtl/core/mtbs_checker.sv =====
// Port-level checker for the bracket search top level, bound in below.
// Depends on mtbs_pkg and monotone_table_bracket_search_top.
module mtbs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       pready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mtbs_pkg::IDX_W-1:0] lower_index,
  input logic [mtbs_pkg::IDX_W-1:0] upper_index
);
  import mtbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lower_index) && $stable(upper_index))
    else $error("result changed or dropped while stalled");

  a_bracket_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (upper_index == lower_index) || (upper_index == lower_index + IDX_W'(1)))
    else $error("bracket is not a single interval");

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("config port stalled");

endmodule

bind monotone_table_bracket_search_top mtbs_checker u_mtbs_checker (
  .clk         (clk),
  .rst         (rst),
  .pready      (pready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .lower_index (lower_index),
  .upper_index (upper_index)
);

// ===== sim/bracket_checker.sv =====
// Checker for the monotone table bracket search block: mirrors the table and last_index,
// predicts the bracket of every accepted search and compares it with each result transaction.
// Depends on mtbs_pkg.
module bracket_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [mtbs_pkg::PADDR_W-1:0] paddr,
  input  logic [mtbs_pkg::PDATA_W-1:0] pwdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         command,
  input  logic [mtbs_pkg::IDX_W-1:0]   entry_index,
  input  logic [mtbs_pkg::DATA_W-1:0]  entry_value,
  input  logic [mtbs_pkg::DATA_W-1:0]  query,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [mtbs_pkg::IDX_W-1:0]   lower_index,
  input  logic [mtbs_pkg::IDX_W-1:0]   upper_index,
  output int                           mismatches,
  output int                           outstanding
);
  import mtbs_pkg::*;

  localparam logic [PADDR_W-1:0] LAST_INDEX_ADDR = PADDR_W'(4 * int'(REG_LAST_INDEX));

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } bracket_t;

  logic signed [DATA_W-1:0] mirror_table [TABLE_DEPTH];
  logic [IDX_W-1:0]         mirror_last;
  bracket_t                 pending_brackets [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string note);
    $display("%0t: %s", $time, note);
    mismatches++;
  endtask

  function automatic bracket_t bisect_table(input logic signed [DATA_W-1:0] x);
    int unsigned n, lo, hi, mid;
    logic        rising, above;
    bracket_t    res;
    n = mirror_last;
    if (n > TABLE_DEPTH - 1) n = TABLE_DEPTH - 1;
    lo = 0;
    hi = n;
    rising = mirror_table[n] >= mirror_table[0];
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      above = x >= mirror_table[mid];
      if (above == rising) lo = mid;
      else hi = mid;
    end
    res.lo = IDX_W'(lo);
    res.hi = IDX_W'(hi);
    return res;
  endfunction

  always @(posedge clk) begin
    bracket_t want;
    if (rst) begin
      mirror_last = '0;
      pending_brackets.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LAST_INDEX_ADDR)
        mirror_last = pwdata[IDX_W-1:0];
      if (out_valid && out_ready) begin
        if (pending_brackets.size() == 0) begin
          report_mismatch($sformatf("result %0d..%0d with no search pending",
                                    lower_index, upper_index));
        end else begin
          want = pending_brackets.pop_front();
          if (lower_index !== want.lo)
            report_mismatch($sformatf("lower_index %0d, expected %0d", lower_index, want.lo));
          if (upper_index !== want.hi)
            report_mismatch($sformatf("upper_index %0d, expected %0d", upper_index, want.hi));
        end
      end
      if (in_valid && in_ready) begin
        if (command == CMD_LOAD) begin
          if (entry_index < TABLE_DEPTH) mirror_table[entry_index] = entry_value;
        end else begin
          pending_brackets.push_back(bisect_table($signed(query)));
        end
      end
    end
    outstanding <= pending_brackets.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the monotone table bracket search block: clock, reset, APB writes,
// table loads and searches under varied idling, and the final verdict.
// Depends on mtbs_pkg, monotone_table_bracket_search_top and bracket_checker.
module tb_top;
  import mtbs_pkg::*;

  localparam int DEPTH         = 1024;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int FULL_SEARCHES = 40;
  // directed cases and the pressure burst
  localparam int EXTRA_ITEMS   = 60;
  localparam int LOOP_ITEMS    = RANDOM_ITEMS - DEPTH - FULL_SEARCHES - EXTRA_ITEMS;
  localparam logic [DATA_W-1:0] MIN_VAL = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MAX_VAL = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] NEG_ONE = 32'hffff_ffff;
  localparam logic [PADDR_W-1:0] LAST_INDEX_ADDR = PADDR_W'(4 * int'(REG_LAST_INDEX));

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = CMD_LOAD;
  logic [IDX_W-1:0]   entry_index = '0;
  logic [DATA_W-1:0]  entry_value = '0;
  logic [DATA_W-1:0]  query = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [IDX_W-1:0]   lower_index;
  logic [IDX_W-1:0]   upper_index;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  logic hold_start = 1'b0;
  int cur_last = 0;
  logic [DATA_W-1:0] plan [DEPTH];

  monotone_table_bracket_search_top #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .entry_index(entry_index), .entry_value(entry_value), .query(query),
    .out_valid(out_valid), .out_ready(out_ready),
    .lower_index(lower_index), .upper_index(upper_index)
  );

  bracket_checker #(.TABLE_DEPTH(DEPTH)) bracket_watch (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready), .command(command),
    .entry_index(entry_index), .entry_value(entry_value), .query(query),
    .out_valid(out_valid), .out_ready(out_ready),
    .lower_index(lower_index), .upper_index(upper_index),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random back-pressure, or a long hold-off once requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_start) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic offer(input logic cmd, input logic [IDX_W-1:0] idx,
                       input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] q);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    entry_index <= idx;
    entry_value <= val;
    query       <= q;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic load_entry(input int idx, input logic [DATA_W-1:0] val);
    plan[idx] = val;
    offer(CMD_LOAD, IDX_W'(idx), val, $urandom());
  endtask

  task automatic search(input logic [DATA_W-1:0] q);
    offer(CMD_SEARCH, IDX_W'($urandom()), $urandom(), q);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_last_index(input int n);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LAST_INDEX_ADDR;
    pwdata  <= ($urandom() & ~32'h3ff) | PDATA_W'(n);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_last = n;
  endtask

  function automatic logic [DATA_W-1:0] pick_query();
    int k;
    logic [DATA_W-1:0] base;
    k = $urandom_range(99);
    base = plan[$urandom_range(cur_last)];
    if (k < 40) return base;
    if (k < 65) return base + DATA_W'($urandom_range(6)) - 32'd3;
    if (k < 75) return $urandom_range(1) ? MIN_VAL : MAX_VAL;
    return $urandom();
  endfunction

  // shapes: rising with repeats, rising, falling, flat, unordered
  task automatic fill_table(input int n);
    int shape, i;
    longint v;
    int unsigned step_max;
    logic [DATA_W-1:0] t;
    shape = $urandom_range(9);
    v = longint'($urandom_range(2000000000)) - 64'sd2147483648;
    if (shape < 2) step_max = 3;
    else if (shape == 8) step_max = 0;
    else step_max = 32'((64'sd2147483647 - v) / (n + 1));
    for (i = 0; i <= n; i++) begin
      plan[i] = (shape == 9) ? $urandom() : DATA_W'(v);
      v += $urandom_range(step_max);
    end
    if (shape >= 5 && shape <= 7) begin
      for (i = 0; i < (n + 1) / 2; i++) begin
        t = plan[i];
        plan[i] = plan[n - i];
        plan[n - i] = t;
      end
    end
    if ($urandom_range(1)) begin
      for (i = 0; i <= n; i++) load_entry(i, plan[i]);
    end else begin
      for (i = n; i >= 0; i--) load_entry(i, plan[i]);
    end
  endtask

  task automatic run_phase(input int n, input int count);
    int j, idx;
    fill_table(n);
    settle();
    write_last_index(n);
    for (j = 0; j < count; j++) begin
      if ($urandom_range(99) < 15) begin
        idx = $urandom_range(DEPTH - 1);
        load_entry(idx, (idx <= n && $urandom_range(9) < 7) ? plan[idx] : $urandom());
      end else begin
        search(pick_query());
      end
    end
  endtask

  task automatic directed_cases();
    write_last_index(0);
    load_entry(0, MIN_VAL);
    search(MAX_VAL);
    search(MIN_VAL);
    load_entry(1, MAX_VAL);
    settle();
    write_last_index(1);
    search('0);
    load_entry(1, NEG_ONE);
    load_entry(2, '0);
    load_entry(3, MAX_VAL);
    settle();
    write_last_index(3);
    search(MIN_VAL);
    search(MAX_VAL);
    search(NEG_ONE);
    search('0);
    search(MAX_VAL - 1);
    // same span, falling
    load_entry(0, MAX_VAL);
    load_entry(1, '0);
    load_entry(2, NEG_ONE);
    load_entry(3, MIN_VAL);
    search(MIN_VAL);
    search(MAX_VAL);
    search('0);
    search(NEG_ONE);
    load_entry(DEPTH - 1, '0);
  endtask

  initial begin
    int base, n;
    bit pressed;
    pressed = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    set_idling(22, 80);
    directed_cases();
    base = sent;
    while (sent - base < LOOP_ITEMS) begin
      if (sent - base < LOOP_ITEMS / 3) begin
        set_idling(22, 80);
      end else if (sent - base < 2 * LOOP_ITEMS / 3) begin
        set_idling(80, 22);
      end else begin
        set_idling(0, 0);
        if (!pressed) begin
          settle();
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
          repeat (30) search(pick_query());
          pressed = 1'b1;
        end
      end
      if ($urandom_range(99) < 45) n = $urandom_range(15);
      else n = $urandom_range(40, 16);
      run_phase(n, $urandom_range(30, 10));
    end
    run_phase(DEPTH - 1, FULL_SEARCHES);
    settle();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
